>>> rtl/chead_pkg.sv
package chead_pkg;

   localparam int DEF_CORDIC_STAGES = 16;
   localparam int DEF_SAMPLE_WIDTH  = 16;
   localparam int TABLE_LEN         = 24;

   localparam int MAG_WIDTH  = 16;
   localparam int HEAD_WIDTH = 15;
   localparam int DECL_WIDTH = 15;
   localparam int PRESCALE   = 24;
   // |x| is at most 2^15, times 2^24, grown by the CORDIC gain and sqrt(2)
   localparam int CX_WIDTH   = 44;
   localparam int Z_WIDTH    = 25;
   localparam int A_WIDTH    = 13;
   localparam int H_WIDTH    = 17;
   localparam int ROUND_SHIFT = 10;

   localparam logic signed [DECL_WIDTH-1:0] DECL_RESET = 15'sd367;
   localparam logic signed [Z_WIDTH-1:0]    DEG90_FINE = 25'sd5898240;
   localparam logic signed [Z_WIDTH-1:0]    ROUND_HALF = 25'sd512;
   localparam logic signed [H_WIDTH-1:0]    FULL_TURN  = 17'sd23040;
   localparam logic signed [H_WIDTH-1:0]    HALF_TURN  = 17'sd11520;
   localparam logic [HEAD_WIDTH-1:0]        HEAD_MAX   = 15'd23040;

   typedef struct packed {
      logic signed [CX_WIDTH-1:0] cx;
      logic signed [CX_WIDTH-1:0] cy;
      logic signed [Z_WIDTH-1:0]  z;
      logic                       x_neg;
      logic                       y_neg;
      logic                       zero;
   } cordic_data_type;

   // atan(2^-idx) in 1/65536 degree, rounded
   function automatic logic signed [Z_WIDTH-1:0] atan_fine(input int idx);
      logic signed [Z_WIDTH-1:0] val;
      case (idx)
         0:  val = 25'sd2949120;
         1:  val = 25'sd1740967;
         2:  val = 25'sd919879;
         3:  val = 25'sd466945;
         4:  val = 25'sd234379;
         5:  val = 25'sd117304;
         6:  val = 25'sd58666;
         7:  val = 25'sd29335;
         8:  val = 25'sd14668;
         9:  val = 25'sd7334;
         10: val = 25'sd3667;
         11: val = 25'sd1833;
         12: val = 25'sd917;
         13: val = 25'sd458;
         14: val = 25'sd229;
         15: val = 25'sd115;
         16: val = 25'sd57;
         17: val = 25'sd29;
         18: val = 25'sd14;
         19: val = 25'sd7;
         20: val = 25'sd4;
         21: val = 25'sd2;
         22: val = 25'sd1;
         default: val = 25'sd0;
      endcase
      return val;
   endfunction

endpackage

>>> rtl/compass_heading_atan2.sv
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  req_mag_x, req_mag_y (signed 16)
// rsp      out        rsp_valid/rsp_stall  rsp_heading (unsigned 15, 1/64 deg)
// csr      in         csr_wr_en            csr_wr_data (declination, signed 15)
//
// One sample per cycle while rsp_stall is low. Stages: one input
// stage, one cell per CORDIC iteration, two stages for rounding and wrap.
// Reset clears all valid flags and loads the declination with 367.
// Each stage holds its item only while the next one is full and stalled,
// so empty slots are filled and req_stall rises only when every stage is
// occupied and rsp_stall is high.
module compass_heading_atan2 import chead_pkg::*; #(
   parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
   parameter int SAMPLE_WIDTH  = DEF_SAMPLE_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [MAG_WIDTH-1:0]  req_mag_x,
   input  logic signed [MAG_WIDTH-1:0]  req_mag_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [HEAD_WIDTH-1:0]        rsp_heading,
   input  logic                         csr_wr_en,
   input  logic signed [DECL_WIDTH-1:0] csr_wr_data
);

   localparam int NUM_STAGES = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

   logic signed [DECL_WIDTH-1:0] decl_ff;
   logic                         prep_ready;
   logic                         cv [NUM_STAGES+1];
   logic                         cr [NUM_STAGES+1];
   cordic_data_type              cd [NUM_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         decl_ff <= DECL_RESET;
      end else if (csr_wr_en) begin
         decl_ff <= csr_wr_data;
      end
   end

   chead_prep #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (prep_ready),
      .mag_x     (req_mag_x),
      .mag_y     (req_mag_y),
      .out_valid (cv[0]),
      .out_data  (cd[0]),
      .out_ready (cr[0])
   );

   assign req_stall = !prep_ready;

   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_cell
      chead_cell #(
         .STAGE(k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[k]),
         .in_ready  (cr[k]),
         .in_data   (cd[k]),
         .out_valid (cv[k+1]),
         .out_data  (cd[k+1]),
         .out_ready (cr[k+1])
      );
   end

   chead_wrap u_wrap (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (cv[NUM_STAGES]),
      .in_ready    (cr[NUM_STAGES]),
      .in_data     (cd[NUM_STAGES]),
      .decl        (decl_ff),
      .out_valid   (rsp_valid),
      .out_heading (rsp_heading),
      .out_ready   (!rsp_stall)
   );

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input held back while the output is free");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (cv[0] && cv[NUM_STAGES]))
      else $error("input held back with an empty stage");

endmodule

>>> rtl/chead_prep.sv
module chead_prep import chead_pkg::*; #(
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic signed [MAG_WIDTH-1:0] mag_x,
   input  logic signed [MAG_WIDTH-1:0] mag_y,
   output logic                        out_valid,
   output cordic_data_type             out_data,
   input  logic                        out_ready
);

   logic                                 valid_ff;
   cordic_data_type                      data_ff;
   cordic_data_type                      data_in;
   logic signed [SAMPLE_WIDTH-1:0]       xs;
   logic signed [SAMPLE_WIDTH-1:0]       ys;
   logic signed [MAG_WIDTH:0]            xe;
   logic signed [MAG_WIDTH:0]            ye;
   logic signed [MAG_WIDTH:0]            ax;
   logic signed [MAG_WIDTH:0]            ay;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      xs = mag_x[SAMPLE_WIDTH-1:0];
      ys = mag_y[SAMPLE_WIDTH-1:0];
      xe = (MAG_WIDTH+1)'(xs);
      ye = (MAG_WIDTH+1)'(ys);
      ax = xe[MAG_WIDTH] ? -xe : xe;
      ay = ye[MAG_WIDTH] ? -ye : ye;
      data_in.cx    = CX_WIDTH'(ax) <<< PRESCALE;
      data_in.cy    = CX_WIDTH'(ay) <<< PRESCALE;
      data_in.z     = '0;
      data_in.x_neg = xs[SAMPLE_WIDTH-1];
      data_in.y_neg = ys[SAMPLE_WIDTH-1];
      data_in.zero  = (xs == '0) && (ys == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/chead_cell.sv
module chead_cell import chead_pkg::*; #(
   parameter int STAGE = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  cordic_data_type in_data,
   output logic            out_valid,
   output cordic_data_type out_data,
   input  logic            out_ready
);

   localparam logic signed [Z_WIDTH-1:0] ANGLE = atan_fine(STAGE);

   logic                       valid_ff;
   cordic_data_type            data_ff;
   cordic_data_type            data_in;
   logic signed [CX_WIDTH-1:0] sx;
   logic signed [CX_WIDTH-1:0] sy;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in = in_data;
      sx = in_data.cx >>> STAGE;
      sy = in_data.cy >>> STAGE;
      // rotate toward the x axis
      if (!in_data.cy[CX_WIDTH-1]) begin
         data_in.cx = in_data.cx + sy;
         data_in.cy = in_data.cy - sx;
         data_in.z  = in_data.z + ANGLE;
      end else begin
         data_in.cx = in_data.cx - sy;
         data_in.cy = in_data.cy + sx;
         data_in.z  = in_data.z - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/chead_wrap.sv
module chead_wrap import chead_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  cordic_data_type              in_data,
   input  logic signed [DECL_WIDTH-1:0] decl,
   output logic                         out_valid,
   output logic [HEAD_WIDTH-1:0]        out_heading,
   input  logic                         out_ready
);

   logic                        hv_ff;
   logic signed [H_WIDTH-1:0]   h_ff;
   logic signed [H_WIDTH-1:0]   h_in;
   logic                        ov_ff;
   logic [HEAD_WIDTH-1:0]       head_ff;
   logic [HEAD_WIDTH-1:0]       head_in;
   logic                        h_ready;
   logic signed [Z_WIDTH-1:0]   zc;
   logic signed [Z_WIDTH-1:0]   zr;
   logic [A_WIDTH-1:0]          ang;
   logic signed [H_WIDTH-1:0]   ah;
   logic signed [H_WIDTH-1:0]   hq;
   logic signed [H_WIDTH-1:0]   w1;
   logic signed [H_WIDTH-1:0]   w2;

   assign h_ready  = !ov_ff || out_ready;
   assign in_ready = !hv_ff || h_ready;

   // clamp to 0..90 degrees, round to 1/64 degree, restore the quadrant
   always_comb begin
      zc = in_data.z;
      if (in_data.z[Z_WIDTH-1]) begin
         zc = '0;
      end else if (in_data.z > DEG90_FINE) begin
         zc = DEG90_FINE;
      end
      zr  = zc + ROUND_HALF;
      ang = in_data.zero ? '0 : zr[ROUND_SHIFT +: A_WIDTH];
      ah  = signed'({{(H_WIDTH-A_WIDTH){1'b0}}, ang});
      if (!in_data.x_neg) begin
         hq = in_data.y_neg ? -ah : ah;
      end else begin
         hq = in_data.y_neg ? (ah - HALF_TURN) : (HALF_TURN - ah);
      end
      h_in = hq - H_WIDTH'(decl);
   end

   // a far negative value needs the full turn added twice
   always_comb begin
      if (h_ff[H_WIDTH-1]) begin
         w1 = h_ff + FULL_TURN;
      end else if (h_ff > FULL_TURN) begin
         w1 = h_ff - FULL_TURN;
      end else begin
         w1 = h_ff;
      end
      w2 = w1[H_WIDTH-1] ? (w1 + FULL_TURN) : w1;
      head_in = w2[HEAD_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            hv_ff <= in_valid;
         end
         if (h_ready) begin
            ov_ff <= hv_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         h_ff <= h_in;
      end
      if (h_ready && hv_ff) begin
         head_ff <= head_in;
      end
   end

   assign out_valid   = ov_ff;
   assign out_heading = head_ff;

   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_heading <= HEAD_MAX)
      else $error("heading above full turn");

endmodule
